// ----- hw/rtl/stack_machine_execute_unit_assert.svh -----
// Assertion macros used by the checker of the stack machine execute unit.
// No dependencies; included by the checker module.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SMEU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SMEU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/smeu_pkg.sv -----
// Package of the stack machine execute unit: sizes, widths, opcodes, status codes and divider types.
// No dependencies; imported by smeu_div, the top level and the checker.
`default_nettype none
package smeu_pkg;
    localparam int StackDepth   = 256;
    localparam int RegCount     = 16;
    localparam int ProgramBytes = 1024;
    localparam int SpW = $clog2(StackDepth);
    localparam int CntW = $clog2(StackDepth + 1);
    localparam int RegW = (RegCount > 1) ? $clog2(RegCount) : 1;

    typedef enum logic [3:0] {
        OP_NOP = 4'd0, OP_PUSH = 4'd1, OP_POP = 4'd2, OP_LOAD = 4'd3,
        OP_STORE = 4'd4, OP_JMP = 4'd5, OP_JZ = 4'd6, OP_JNZ = 4'd7,
        OP_ADD = 4'd8, OP_SUB = 4'd9, OP_MUL = 4'd10, OP_DIV = 4'd11,
        OP_PRINT = 4'd12, OP_STOP = 4'd13, OP_BAD14 = 4'd14, OP_BAD15 = 4'd15
    } op_t;

    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_STOP = 4'd1, ST_OVER = 4'd2, ST_UNDER = 4'd3,
        ST_BADREG = 4'd4, ST_BADTGT = 4'd5, ST_DIVZ = 4'd6, ST_HALTED = 4'd7,
        ST_BADOP = 4'd8
    } status_t;

    typedef struct packed {
        logic start;
        logic neg;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- hw/rtl/smeu_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module smeu_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/smeu_div.sv -----
// Radix-2 restoring divider of unsigned magnitudes with sign fix-up, one bit a cycle.
// Depends on smeu_pkg.
`default_nettype none
module smeu_div
    import smeu_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire div_req_t req,
    output div_rsp_t  rsp
);
    logic [31:0] quo_reg, rem_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, neg_reg, done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                den_reg  <= req.divisor;
                neg_reg  <= req.neg;
            end else if (busy_reg) begin
                if (trial[32]) begin
                    rem_reg <= {rem_reg[30:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end else begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/stack_machine_execute_unit.sv -----
// Top level of the stack machine execute unit: sequencer, stack RAM, register RAM.
// Depends on smeu_pkg, smeu_ram and smeu_div.
//
// Usage: one decoded instruction enters on the s_axis word, one result word leaves
// on the m_axis word. s_tdata = {operand[31:0], action[3:0]}; m_tdata carries status,
// print_valid, print_value, jump_taken and jump_target from the lowest bit up.
// Items are handled one at a time by a read-modify-write sequencer over the stack RAM
// (single read port, registered read) and the register RAM. Every item first
// reads the top two stack entries (states RD1, RD2) and is then executed (EXEC);
// add, sub and mul pass through an extra write-back state (S_DIV), in which div
// also waits for the shift-subtract divider, one quotient bit a cycle. m_tvalid
// rises in S_OUT, and s_tready returns high in the cycle after the result is
// delivered. The result sits in an output register; a stalled receiver holds the
// block. Reset clears the stack count, the halt flag and the register valid bits
// (unwritten registers read as zero); the stack contents are not cleared.
`default_nettype none
module stack_machine_execute_unit
    import smeu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // action[3:0], operand[35:4], zeros
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // status[3:0], print_valid[4],
                                        // print_value[36:5], jump_taken[37],
                                        // jump_target[53:38], zeros
);
    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_OUT
    } state_t;

    state_t          state_reg;
    logic [3:0]      op_reg;
    logic [31:0]     arg_reg, s1_reg, s2_reg;
    logic [CntW-1:0] cnt_reg;
    logic            halted_reg;
    logic [RegCount-1:0] rvalid_reg;
    logic [3:0]      status_reg;
    logic            pvalid_reg, jtaken_reg;
    logic [31:0]     pval_reg;
    logic [15:0]     jtgt_reg;

    logic             st_we, rf_we;
    logic [SpW-1:0]   st_waddr, st_raddr;
    logic [31:0]      st_wdata, st_rdata, rf_rdata, rf_wdata;
    logic [RegW-1:0]  rf_waddr, rf_raddr;
    div_req_t         dreq;
    div_rsp_t         drsp;

    logic reg_ok, tgt_ok, full, has1, has2;
    logic [63:0] prod;

    assign reg_ok = arg_reg < 32'(RegCount);
    assign tgt_ok = arg_reg < 32'(ProgramBytes);
    assign full   = cnt_reg == CntW'(StackDepth);
    assign has1   = cnt_reg != '0;
    assign has2   = cnt_reg > CntW'(1);
    assign prod   = s2_reg * s1_reg;

    smeu_ram #(.Width(32), .Depth(StackDepth)) u_stack (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );
    smeu_ram #(.Width(32), .Depth(RegCount)) u_regs (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_raddr), .rdata(rf_rdata)
    );
    smeu_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    // Read addresses: the entry below the top in RD1, else the top; data is captured in RD1 and RD2.
    always_comb begin
        st_raddr = SpW'(cnt_reg - CntW'(1));
        if (state_reg == S_RD1) begin
            st_raddr = SpW'(cnt_reg - CntW'(2));
        end
        rf_raddr = RegW'(arg_reg);
    end

    always_ff @(posedge aclk) begin
        st_we <= 1'b0;
        rf_we <= 1'b0;
        dreq.start <= 1'b0;
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
            rvalid_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tdata[3:0];
                        arg_reg   <= s_tdata[35:4];
                        state_reg <= S_RD1;
                    end
                end
                S_RD1: begin
                    s1_reg    <= st_rdata;
                    state_reg <= S_RD2;
                end
                S_RD2: begin
                    s2_reg    <= st_rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    status_reg <= ST_OK;
                    pvalid_reg <= 1'b0;
                    pval_reg   <= '0;
                    jtaken_reg <= 1'b0;
                    jtgt_reg   <= '0;
                    state_reg  <= S_OUT;
                    if (halted_reg) begin
                        status_reg <= ST_HALTED;
                    end else begin
                        unique case (op_t'(op_reg))
                            OP_NOP: ;
                            OP_PUSH, OP_LOAD: begin
                                if (op_reg == OP_LOAD && !reg_ok) begin
                                    status_reg <= ST_BADREG;
                                    halted_reg <= 1'b1;
                                end else if (full) begin
                                    status_reg <= ST_OVER;
                                    halted_reg <= 1'b1;
                                end else begin
                                    st_we    <= 1'b1;
                                    st_waddr <= SpW'(cnt_reg);
                                    st_wdata <= (op_reg == OP_LOAD)
                                        ? (rvalid_reg[RegW'(arg_reg)] ? rf_rdata : '0)
                                        : arg_reg;
                                    cnt_reg  <= cnt_reg + CntW'(1);
                                end
                            end
                            OP_POP, OP_PRINT, OP_STORE: begin
                                if (op_reg == OP_STORE && !reg_ok) begin
                                    status_reg <= ST_BADREG;
                                    halted_reg <= 1'b1;
                                end else if (!has1) begin
                                    status_reg <= ST_UNDER;
                                    halted_reg <= 1'b1;
                                end else begin
                                    cnt_reg <= cnt_reg - CntW'(1);
                                    if (op_reg == OP_PRINT) begin
                                        pvalid_reg <= 1'b1;
                                        pval_reg   <= s1_reg;
                                    end
                                    if (op_reg == OP_STORE) begin
                                        rf_we    <= 1'b1;
                                        rf_waddr <= RegW'(arg_reg);
                                        rf_wdata <= s1_reg;
                                        rvalid_reg[RegW'(arg_reg)] <= 1'b1;
                                    end
                                end
                            end
                            OP_JMP, OP_JZ, OP_JNZ: begin
                                if (!tgt_ok) begin
                                    status_reg <= ST_BADTGT;
                                    halted_reg <= 1'b1;
                                end else if (op_reg != OP_JMP && !has1) begin
                                    status_reg <= ST_UNDER;
                                    halted_reg <= 1'b1;
                                end else if (op_reg == OP_JMP ||
                                             ((op_reg == OP_JZ) == (s1_reg == '0))) begin
                                    jtaken_reg <= 1'b1;
                                    jtgt_reg   <= arg_reg[15:0];
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                if (!has2) begin
                                    status_reg <= ST_UNDER;
                                    halted_reg <= 1'b1;
                                end else if (op_reg == OP_DIV) begin
                                    if (s1_reg == '0) begin
                                        status_reg <= ST_DIVZ;
                                        halted_reg <= 1'b1;
                                    end else begin
                                        dreq.start    <= 1'b1;
                                        dreq.neg      <= s2_reg[31] ^ s1_reg[31];
                                        dreq.dividend <= s2_reg[31]
                                            ? 32'd0 - s2_reg : s2_reg;
                                        dreq.divisor  <= s1_reg[31]
                                            ? 32'd0 - s1_reg : s1_reg;
                                        state_reg <= S_DIV;
                                    end
                                end else begin
                                    // The result is written back in the following
                                    // state, off the registered operands.
                                    state_reg <= S_DIV;
                                end
                            end
                            OP_STOP: begin
                                status_reg <= ST_STOP;
                                halted_reg <= 1'b1;
                            end
                            default: begin
                                status_reg <= ST_BADOP;
                                halted_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (op_reg != OP_DIV || drsp.done) begin
                        st_we    <= 1'b1;
                        st_waddr <= SpW'(cnt_reg - CntW'(2));
                        priority case (1'b1)
                            op_reg == OP_ADD: st_wdata <= s2_reg + s1_reg;
                            op_reg == OP_SUB: st_wdata <= s2_reg - s1_reg;
                            op_reg == OP_MUL: st_wdata <= prod[31:0];
                            default:          st_wdata <= drsp.quotient;
                        endcase
                        cnt_reg   <= cnt_reg - CntW'(1);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = state_reg == S_OUT;
    assign m_tdata  = {2'b00, jtgt_reg, jtaken_reg, pval_reg, pvalid_reg, status_reg};
endmodule
`default_nettype wire

// ----- hw/rtl/smeu_checker.sv -----
// Port-level checker of the stack machine execute unit, bound to the top level.
// Depends on smeu_pkg and stack_machine_execute_unit_assert.svh.
`default_nettype none
`include "stack_machine_execute_unit_assert.svh"
module smeu_checker
    import smeu_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    `SMEU_ASSERT_IMP(a_one_side, aclk, aresetn, m_tvalid, !s_tready)
    `SMEU_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SMEU_ASSERT_IMP(a_print_ok, aclk, aresetn, m_tvalid && m_tdata[4], m_tdata[3:0] == ST_OK)
    `SMEU_ASSERT_IMP(a_jump_ok, aclk, aresetn, m_tvalid && m_tdata[37], m_tdata[3:0] == ST_OK)
    `SMEU_ASSERT_NXT(a_sticky, aclk, aresetn, m_tvalid && m_tready && m_tdata[3:0] != ST_OK && m_tdata[3:0] != ST_HALTED, !m_tvalid)
endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
